// ===== sv/wstd_pkg.sv =====
// Shared constants, command and status types for the slope threshold detector.
`default_nettype none
package wstd_pkg;
   localparam int WINDOW_DEF = 30;
   localparam int SLOTS_DEF  = 5;
   localparam int DATA_W     = 16;
   localparam int ADDR_W     = 16;
   localparam int SLOT_OUT_W = 3;
   localparam int NUM_OUT_W  = 35;
   localparam int NUM_W      = 48;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic update;
      logic scan_rd;
      logic mul;
      logic cmp;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_eval;
      logic scan_last;
      logic out_free;
   } dp_status_type;
endpackage
`default_nettype wire

// ===== sv/wstd_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module wstd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 150
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== sv/wstd_ctrl.sv =====
// Sequencing state machine for the slope threshold detector.
`default_nettype none
module wstd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire wstd_pkg::dp_status_type status,
   output wstd_pkg::ctrl_cmd_type       cmd
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_LOOKUP = 8'b0000_0010,
      S_UPDATE = 8'b0000_0100,
      S_SCAN   = 8'b0000_1000,
      S_DRAIN  = 8'b0001_0000,
      S_MUL    = 8'b0010_0000,
      S_CMP    = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.need_eval ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_MUL;
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

// ===== sv/wstd_dp.sv =====
// Slot table, sample window store, accumulators and output register.
`default_nettype none
module wstd_dp #(
   parameter int WINDOW = wstd_pkg::WINDOW_DEF,
   parameter int SLOTS  = wstd_pkg::SLOTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire wstd_pkg::ctrl_cmd_type              cmd,
   output wstd_pkg::dp_status_type                  status,
   input  wire logic                                req_op,
   input  wire logic [wstd_pkg::ADDR_W-1:0]         req_addr,
   input  wire logic signed [wstd_pkg::DATA_W-1:0]  req_value,
   input  wire logic                                csr_we,
   input  wire logic signed [wstd_pkg::DATA_W-1:0]  csr_wdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [wstd_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int PTR_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int DEPTH  = SLOTS * WINDOW;
   localparam int RA_W   = $clog2(DEPTH);
   localparam int ACC_W  = wstd_pkg::DATA_W + 2 * PTR_W + 2;
   localparam int NW     = wstd_pkg::NUM_W;
   localparam longint SX  = longint'(WINDOW) * (WINDOW - 1) / 2;
   localparam longint SXX = longint'(WINDOW - 1) * WINDOW * (2 * WINDOW - 1) / 6;
   localparam longint DEN = longint'(WINDOW) * SXX - SX * SX;
   localparam logic signed [NW-1:0] WIN_S = NW'(WINDOW);
   localparam logic signed [NW-1:0] SX_S  = NW'(SX);
   localparam logic signed [NW-1:0] DEN_S = NW'(DEN);
   localparam logic [PTR_W-1:0]  LAST_K = PTR_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FULL_F = FILL_W'(WINDOW);

   // Captured request.
   logic                               op_ff;
   logic [wstd_pkg::ADDR_W-1:0]        addr_ff;
   logic signed [wstd_pkg::DATA_W-1:0] val_ff;
   logic signed [wstd_pkg::DATA_W-1:0] thr_ff;

   // Slot table.
   logic [SLOTS-1:0]            in_use_ff;
   logic [wstd_pkg::ADDR_W-1:0] source_ff [SLOTS];
   logic [FILL_W-1:0]           fill_ff   [SLOTS];
   logic [PTR_W-1:0]            oldest_ff [SLOTS];

   // Lookup results.
   logic              hit_ff, free_ok_ff;
   logic [SLOT_W-1:0] hit_slot_ff, free_slot_ff;
   logic              hit_in, free_ok_in;
   logic [SLOT_W-1:0] hit_slot_in, free_slot_in;

   always_comb begin
      hit_in       = 1'b0;
      hit_slot_in  = '0;
      free_ok_in   = 1'b0;
      free_slot_in = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (in_use_ff[s] && source_ff[s] == addr_ff) begin
            hit_in      = 1'b1;
            hit_slot_in = SLOT_W'(s);
         end
         if (!in_use_ff[s]) begin
            free_ok_in   = 1'b1;
            free_slot_in = SLOT_W'(s);
         end
      end
   end

   // Update decisions for a sample.
   logic              smp_ok;
   logic [SLOT_W-1:0] sel_slot;
   logic [FILL_W-1:0] cur_f, new_f;
   logic [PTR_W-1:0]  cur_o, new_o, pos;
   logic [PTR_W:0]    sum_of;
   logic              full;
   logic [RA_W-1:0]   base;

   always_comb begin
      sel_slot = hit_ff ? hit_slot_ff : free_slot_ff;
      smp_ok   = (op_ff == wstd_pkg::OP_SAMPLE) && (hit_ff || free_ok_ff);
      cur_f    = hit_ff ? fill_ff[sel_slot] : '0;
      cur_o    = hit_ff ? oldest_ff[sel_slot] : '0;
      full     = cur_f >= FULL_F;
      sum_of   = {1'b0, cur_o} + (PTR_W + 1)'(cur_f);
      if (full) begin
         pos   = cur_o;
         new_o = (cur_o == LAST_K) ? '0 : cur_o + 1'b1;
         new_f = FULL_F;
      end else begin
         pos   = (sum_of >= (PTR_W + 1)'(WINDOW)) ?
                 PTR_W'(sum_of - (PTR_W + 1)'(WINDOW)) : PTR_W'(sum_of);
         new_o = cur_o;
         new_f = cur_f + 1'b1;
      end
      base = RA_W'(RA_W'(sel_slot) * RA_W'(WINDOW));
   end

   assign status.need_eval = smp_ok && (new_f == FULL_F);

   // Scan state.
   logic [RA_W-1:0]  base_ff;
   logic [PTR_W-1:0] ptr_ff, k_ff, kd_ff;
   logic             rd_v_ff;
   logic signed [ACC_W-1:0] sxy_ff, sy_ff;
   logic signed [wstd_pkg::DATA_W-1:0] rdata;
   logic signed [NW-1:0] p1_ff, p2_ff, num_ff, td_ff;
   logic eval_ff;

   assign status.scan_last = k_ff == LAST_K;

   wstd_ram #(.WIDTH(wstd_pkg::DATA_W), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (cmd.update && smp_ok),
      .waddr (RA_W'(base + RA_W'(pos))),
      .wdata (val_ff),
      .re    (cmd.scan_rd),
      .raddr (RA_W'(base_ff + RA_W'(ptr_ff))),
      .rdata (rdata)
   );

   // Output register.
   logic                         out_v_ff;
   logic                         r_acc_ff, r_eval_ff, r_open_ff;
   logic [wstd_pkg::SLOT_OUT_W-1:0] r_slot_ff;
   logic [wstd_pkg::NUM_OUT_W-1:0]  r_num_ff;
   logic                         res_acc_ff;
   logic [SLOT_W-1:0]            res_slot_ff;

   assign status.out_free = !out_v_ff || rsp_tready;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {7'b0, r_open_ff, r_num_ff, r_eval_ff, r_slot_ff, r_acc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= '0;
         in_use_ff <= '0;
         out_v_ff  <= 1'b0;
         rd_v_ff   <= 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            fill_ff[s]   <= '0;
            oldest_ff[s] <= '0;
         end
      end else begin
         if (csr_we) begin
            thr_ff <= csr_wdata;
         end
         rd_v_ff <= cmd.scan_rd;
         if (cmd.update) begin
            if (op_ff == wstd_pkg::OP_REMOVE) begin
               if (hit_ff) begin
                  in_use_ff[hit_slot_ff] <= 1'b0;
                  fill_ff[hit_slot_ff]   <= '0;
                  oldest_ff[hit_slot_ff] <= '0;
               end
            end else if (smp_ok) begin
               in_use_ff[sel_slot] <= 1'b1;
               fill_ff[sel_slot]   <= new_f;
               oldest_ff[sel_slot] <= new_o;
            end
         end
         if (cmd.emit) begin
            out_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         addr_ff <= req_addr;
         val_ff  <= req_value;
      end
      if (cmd.lookup) begin
         hit_ff       <= hit_in;
         hit_slot_ff  <= hit_slot_in;
         free_ok_ff   <= free_ok_in;
         free_slot_ff <= free_slot_in;
      end
      if (cmd.update) begin
         if (smp_ok && !hit_ff) begin
            source_ff[sel_slot] <= addr_ff;
         end
         base_ff <= base;
         ptr_ff  <= new_o;
         k_ff    <= '0;
         sxy_ff  <= '0;
         sy_ff   <= '0;
         eval_ff <= 1'b0;
         num_ff  <= '0;
         td_ff   <= '0;
         if (op_ff == wstd_pkg::OP_REMOVE) begin
            res_acc_ff  <= hit_ff;
            res_slot_ff <= hit_ff ? hit_slot_ff : '0;
         end else begin
            res_acc_ff  <= smp_ok;
            res_slot_ff <= smp_ok ? sel_slot : '0;
         end
      end
      if (cmd.scan_rd) begin
         ptr_ff <= (ptr_ff == LAST_K) ? '0 : ptr_ff + 1'b1;
         k_ff   <= k_ff + 1'b1;
         kd_ff  <= k_ff;
      end
      if (rd_v_ff) begin
         sxy_ff <= sxy_ff + ACC_W'(rdata) * ACC_W'($signed({1'b0, kd_ff}));
         sy_ff  <= sy_ff + ACC_W'(rdata);
      end
      if (cmd.mul) begin
         p1_ff <= NW'(sxy_ff) * WIN_S;
         p2_ff <= NW'(sy_ff) * SX_S;
      end
      if (cmd.cmp) begin
         num_ff  <= p1_ff - p2_ff;
         td_ff   <= NW'(thr_ff) * DEN_S;
         eval_ff <= 1'b1;
      end
      if (cmd.emit) begin
         r_acc_ff  <= res_acc_ff;
         r_slot_ff <= wstd_pkg::SLOT_OUT_W'(res_slot_ff);
         r_eval_ff <= eval_ff;
         r_num_ff  <= wstd_pkg::NUM_OUT_W'(num_ff);
         r_open_ff <= eval_ff && (num_ff > td_ff);
      end
   end
endmodule
`default_nettype wire

// ===== sv/windowed_slope_threshold_detector_core.sv =====
// Top level of the windowed slope threshold detector.
// The request channel (req_) carries one transaction per sensor sample or per
// source removal; req_tuser selects which. Every request transaction yields
// exactly one response transaction on the rsp_ channel, in order.
// A sample finds or allocates its source's slot, is written into that slot's
// circular window in a RAM, and once the window is full the RAM is walked
// once to build the least-squares sums, followed by the final products.
// A request that is refused, a removal, or a sample into a window that is not
// yet full goes through the lookup and update states and then waits only for
// the response register to be free before its response is loaded.
// A full-window sample also walks its window through the one RAM read port,
// which supplies one stored sample per cycle, and then forms the products and
// the threshold comparison before its response is loaded.
// The block works on one request at a time; req_tready is high only while it
// is idle. The response sits in an output register, so a stalled receiver
// does not block the next request, which is accepted and processed; it only
// waits before being loaded if the previous response is still pending.
// The threshold is written through csr_we and csr_wdata; the user must write it only while idle (not enforced).
// Reset is synchronous and clears the slot table, the threshold and the
// output valid flag; the window RAM needs no clearing.
`default_nettype none
module windowed_slope_threshold_detector_core #(
   parameter int WINDOW = wstd_pkg::WINDOW_DEF,
   parameter int SLOTS  = wstd_pkg::SLOTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [15:0] source_address, [31:16] sample_value
   input  wire logic [wstd_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // [0] op
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] accepted, [3:1] slot_index, [4] evaluated, [39:5] slope_numerator,
   // [40] open_valve, [47:41] zero
   output logic [wstd_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [wstd_pkg::DATA_W-1:0]         csr_wdata
);
   wstd_pkg::ctrl_cmd_type  cmd;
   wstd_pkg::dp_status_type status;

   // The controller only sequences; all state of the table lives in the datapath.
   wstd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   wstd_dp #(.WINDOW(WINDOW), .SLOTS(SLOTS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_op     (req_tuser),
      .req_addr   (req_tdata[15:0]),
      .req_value  ($signed(req_tdata[31:16])),
      .csr_we     (csr_we),
      .csr_wdata  ($signed(csr_wdata)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire
